// File: sv/radix_text_to_fixed_point_macros.svh
// Assertion macros used by the checker file.
`ifndef RADIX_TEXT_TO_FIXED_POINT_MACROS_SVH
`define RADIX_TEXT_TO_FIXED_POINT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RTFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rtfp_pkg.sv
package rtfp_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_POINT   = 8'd46;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UP_A    = 8'd65;
  localparam logic [7:0] CH_UP_F    = 8'd70;
  localparam logic [7:0] CH_UP_Z    = 8'd90;
  localparam logic [7:0] CH_LOW_A   = 8'd97;
  localparam logic [7:0] CH_LOW_Z   = 8'd122;
  localparam logic [7:0] CASE_SHIFT = 8'd32;
  localparam logic [7:0] LETTER_OFS = 8'd55;

  // Radix handling
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] BASE_MIN    = 6'd2;
  localparam logic [5:0] BASE_HEX    = 6'd16;
  localparam logic [5:0] BASE_OCT    = 6'd8;
  localparam logic [5:0] BASE_BIN    = 6'd2;
  localparam logic [5:0] MAX_OCT     = 6'd7;
  localparam logic [5:0] MAX_BIN     = 6'd1;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HEX  = 3'd1;
  localparam logic [2:0] ST_BAD_OCT  = 3'd2;
  localparam logic [2:0] ST_BAD_BIN  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_POINT,
    KIND_DIGIT,
    KIND_BAD
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [5:0]  digit;
    logic [2:0]  code;
    logic        last;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: sv/rtfp_front.sv
module rtfp_front #(
  parameter int LINE_CHARS = 128,
  parameter int POS_W      = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic [5:0]        base,
  input  logic              q_full,
  output logic              push,
  output rtfp_pkg::item_t   push_item,
  output logic [POS_W-1:0]  push_pos
);

  logic [POS_W-1:0] char_pos;
  logic             is_letter;
  logic             is_num;
  logic [7:0]       up;
  logic [5:0]       digit;
  logic [2:0]       code;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign push_pos = char_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= '0;
    end else if (push) begin
      if (last_char) begin
        char_pos <= '0;
      end else if (char_pos != POS_W'(LINE_CHARS - 1)) begin
        char_pos <= char_pos + 1'b1;
      end
    end
  end

  // Classify the character and run the radix checks.
  always_comb begin
    is_letter = ((char_code >= rtfp_pkg::CH_UP_A) && (char_code <= rtfp_pkg::CH_UP_Z)) ||
                ((char_code >= rtfp_pkg::CH_LOW_A) && (char_code <= rtfp_pkg::CH_LOW_Z));
    is_num    = (char_code >= rtfp_pkg::CH_ZERO) && (char_code <= rtfp_pkg::CH_NINE);
    up        = (char_code >= rtfp_pkg::CH_LOW_A) ? char_code - rtfp_pkg::CASE_SHIFT
                                                  : char_code;
    code      = rtfp_pkg::ST_OK;
    if (is_letter) begin
      digit = 6'(up - rtfp_pkg::LETTER_OFS);
      if ((base == rtfp_pkg::BASE_HEX) && (up > rtfp_pkg::CH_UP_F)) begin
        code = rtfp_pkg::ST_BAD_HEX;
      end
    end else begin
      digit = is_num ? 6'(char_code - rtfp_pkg::CH_ZERO) : 6'd0;
      if ((base == rtfp_pkg::BASE_OCT) && (digit > rtfp_pkg::MAX_OCT)) begin
        code = rtfp_pkg::ST_BAD_OCT;
      end else if ((base == rtfp_pkg::BASE_BIN) && (digit > rtfp_pkg::MAX_BIN)) begin
        code = rtfp_pkg::ST_BAD_BIN;
      end
    end

    push_item.digit = digit;
    push_item.code  = code;
    push_item.last  = last_char;
    if (char_code == rtfp_pkg::CH_SPACE) begin
      push_item.kind = rtfp_pkg::KIND_SKIP;
    end else if (char_code == rtfp_pkg::CH_POINT) begin
      push_item.kind = rtfp_pkg::KIND_POINT;
    end else if (code != rtfp_pkg::ST_OK) begin
      push_item.kind = rtfp_pkg::KIND_BAD;
    end else begin
      push_item.kind = rtfp_pkg::KIND_DIGIT;
    end
  end

endmodule

// File: sv/rtfp_queue.sv
module rtfp_queue #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] pop_data
);

  // Two-entry queue between classifier and executor.
  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: sv/rtfp_div.sv
module rtfp_div #(
  parameter int W = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [5:0]            divisor,
  output rtfp_pkg::div_status_t stat,
  output logic [W-1:0]          quotient
);

  // Restoring divider, one quotient bit per cycle.
  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]     dq;
  logic [5:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [6:0]       trial;
  logic             ge;

  assign trial    = {rem, dq[W-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign quotient = dq;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below the divisor, so six bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 6'(trial - {1'b0, divisor}) : trial[5:0];
      dq  <= {dq[W-2:0], ge};
    end
  end

endmodule

// File: sv/rtfp_back.sv
module rtfp_back #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 24,
  parameter int POS_W     = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [5:0]            base,
  input  logic                  q_nonempty,
  input  rtfp_pkg::item_t       q_item,
  input  logic [POS_W-1:0]      q_pos,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INT_BITS-1:0]   integer_value,
  output logic [FRAC_BITS-1:0]  fraction_value,
  output logic                  has_point,
  output logic [2:0]            status,
  output logic [6:0]            error_index
);

  localparam int IW = INT_BITS + 7;
  localparam int FW = FRAC_BITS + 7;

  rtfp_pkg::back_state_t state, state_next;

  logic [INT_BITS-1:0]  int_acc, int_acc_next;
  logic [FRAC_BITS-1:0] frac_acc, frac_acc_next;
  logic [FRAC_BITS-1:0] frac_weight, frac_weight_next;
  logic                 in_fraction, in_fraction_next;
  logic [2:0]           err_code, err_code_next;
  logic [POS_W-1:0]     err_pos, err_pos_next;
  logic                 pend_last, pend_last_next;
  logic                 out_valid_next;
  logic                 load_out;

  logic [IW-1:0]        int_sum;
  logic                 int_ovf;
  logic [FW-1:0]        frac_sum;
  logic                 frac_sat;
  logic [POS_W+6:0]     pos_ext;

  logic                 div_start;
  logic [FRAC_BITS:0]   div_dividend;
  logic [FRAC_BITS:0]   div_quot;
  rtfp_pkg::div_status_t div_stat;

  assign int_sum  = IW'(int_acc) * IW'(base) + IW'(q_item.digit);
  assign int_ovf  = |int_sum[IW-1:INT_BITS];
  assign frac_sum = FW'(frac_weight) * FW'(q_item.digit) + FW'(frac_acc);
  assign frac_sat = |frac_sum[FW-1:FRAC_BITS];
  assign pos_ext  = {7'b0, err_pos};

  rtfp_div #(.W(FRAC_BITS + 1)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rtfp_pkg::BK_IDLE;
      int_acc     <= '0;
      frac_acc    <= '0;
      frac_weight <= '0;
      in_fraction <= 1'b0;
      err_code    <= rtfp_pkg::ST_OK;
      err_pos     <= '0;
      pend_last   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      int_acc     <= int_acc_next;
      frac_acc    <= frac_acc_next;
      frac_weight <= frac_weight_next;
      in_fraction <= in_fraction_next;
      err_code    <= err_code_next;
      err_pos     <= err_pos_next;
      pend_last   <= pend_last_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      integer_value  <= int_acc;
      fraction_value <= frac_acc;
      has_point      <= in_fraction;
      status         <= err_code;
      error_index    <= (err_code != rtfp_pkg::ST_OK) ? pos_ext[6:0] : 7'd0;
    end
  end

  always_comb begin
    state_next       = state;
    int_acc_next     = int_acc;
    frac_acc_next    = frac_acc;
    frac_weight_next = frac_weight;
    in_fraction_next = in_fraction;
    err_code_next    = err_code;
    err_pos_next     = err_pos;
    pend_last_next   = pend_last;
    out_valid_next   = out_valid && !out_ready;
    load_out         = 1'b0;
    pop              = 1'b0;
    div_start        = 1'b0;
    div_dividend     = {1'b0, frac_weight};

    case (state)
      rtfp_pkg::BK_IDLE: begin
        if (q_nonempty) begin
          pop            = 1'b1;
          pend_last_next = q_item.last;
          if (err_code == rtfp_pkg::ST_OK) begin
            case (q_item.kind)
              rtfp_pkg::KIND_POINT: begin
                if (!in_fraction) begin
                  in_fraction_next = 1'b1;
                  div_start        = 1'b1;
                  div_dividend     = {1'b1, {FRAC_BITS{1'b0}}};
                end
              end
              rtfp_pkg::KIND_BAD: begin
                err_code_next = q_item.code;
                err_pos_next  = q_pos;
              end
              rtfp_pkg::KIND_DIGIT: begin
                if (!in_fraction) begin
                  if (int_ovf) begin
                    int_acc_next  = '1;
                    err_code_next = rtfp_pkg::ST_OVERFLOW;
                    err_pos_next  = q_pos;
                  end else begin
                    int_acc_next = int_sum[INT_BITS-1:0];
                  end
                end else begin
                  frac_acc_next = frac_sat ? '1 : frac_sum[FRAC_BITS-1:0];
                  div_start     = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          if (div_start) begin
            state_next = rtfp_pkg::BK_DIV;
          end else if (q_item.last) begin
            state_next = rtfp_pkg::BK_FINISH;
          end
        end
      end
      rtfp_pkg::BK_DIV: begin
        if (div_stat.done) begin
          frac_weight_next = div_quot[FRAC_BITS-1:0];
          state_next       = pend_last ? rtfp_pkg::BK_FINISH : rtfp_pkg::BK_IDLE;
        end
      end
      rtfp_pkg::BK_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out         = 1'b1;
          out_valid_next   = 1'b1;
          int_acc_next     = '0;
          frac_acc_next    = '0;
          frac_weight_next = '0;
          in_fraction_next = 1'b0;
          err_code_next    = rtfp_pkg::ST_OK;
          err_pos_next     = '0;
          state_next       = rtfp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rtfp_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// File: sv/radix_text_to_fixed_point.sv
// Converts the text of a number in base radix (2..36, reset 10; 0 and 1 act
// as 2) into an integer part and an unsigned fraction, one character per input
// request, with last_char flagging the final character of a line. Spaces are
// dropped, the first '.' opens the fraction and later dots are dropped;
// letters count as 10..35 and any other non-digit counts as 0. In base 16 a
// letter above F, in base 8 a digit above 7 and in base 2 a digit above 1 is
// an error: the first error (or an integer overflow, which saturates
// integer_value to all ones) is kept with its character position and the rest
// of the line is ignored. One result request leaves on the last character.
// A classifier takes characters into a two-entry queue, and an executor
// works them off. Spaces, dots after the first, integer digits and
// erroring characters need the executor alone; the first dot and each
// fraction digit also start the bit-serial divider that divides the
// fraction weight by the base, and the executor waits for its result. After
// the last character of a line a finish state hands the result to the output
// register, which holds it while the next line is already being taken in.
// The radix register may be rewritten only while the block is idle.
module radix_text_to_fixed_point #(
  parameter int LINE_CHARS = 128,
  parameter int INT_BITS   = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [5:0]           radix,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INT_BITS-1:0]  integer_value,
  output logic [FRAC_BITS-1:0] fraction_value,
  output logic                 has_point,
  output logic [2:0]           status,
  output logic [6:0]           error_index
);

  localparam int POS_W  = $clog2(LINE_CHARS);
  localparam int ITEM_W = $bits(rtfp_pkg::item_t);
  localparam int Q_W    = ITEM_W + POS_W;

  logic [5:0]       radix_q;
  logic [5:0]       base;

  logic             push;
  rtfp_pkg::item_t  push_item;
  logic [POS_W-1:0] push_pos;
  logic             q_full;
  logic             q_nonempty;
  logic             pop;
  logic [Q_W-1:0]   q_data;

  // Radix register; a write request is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_q <= rtfp_pkg::RADIX_RESET;
    end else if (cfg_valid) begin
      radix_q <= radix;
    end
  end

  // Clamp small radix values to base 2.
  assign base = (radix_q < rtfp_pkg::BASE_MIN) ? rtfp_pkg::BASE_MIN : radix_q;

  rtfp_front #(
    .LINE_CHARS (LINE_CHARS),
    .POS_W      (POS_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .base      (base),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .push_pos  (push_pos)
  );

  rtfp_queue #(.W(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_item, push_pos}),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_data)
  );

  rtfp_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS),
    .POS_W     (POS_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .base           (base),
    .q_nonempty     (q_nonempty),
    .q_item         (rtfp_pkg::item_t'(q_data[Q_W-1:POS_W])),
    .q_pos          (q_data[POS_W-1:0]),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .integer_value  (integer_value),
    .fraction_value (fraction_value),
    .has_point      (has_point),
    .status         (status),
    .error_index    (error_index)
  );

endmodule

// File: sv/rtfp_checker.sv
`include "radix_text_to_fixed_point_macros.svh"

module rtfp_checker #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 24
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [7:0]           char_code,
  input logic                 last_char,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [INT_BITS-1:0]  integer_value,
  input logic [FRAC_BITS-1:0] fraction_value,
  input logic                 has_point,
  input logic [2:0]           status,
  input logic [6:0]           error_index
);

  // Hold a waiting input request.
  `RTFP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(char_code) && $stable(last_char),
    "input request changed while waiting")

  // Hold a stalled result.
  `RTFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(integer_value) && $stable(fraction_value) &&
    $stable(has_point) && $stable(status) && $stable(error_index),
    "result changed while stalled")

  `RTFP_ASSERT_NOW(a_ok_index, out_valid && (status == rtfp_pkg::ST_OK),
    error_index == 7'd0, "error index set on clean result")

  `RTFP_ASSERT_NOW(a_status_range, out_valid, status <= rtfp_pkg::ST_OVERFLOW,
    "status code out of range")

  `RTFP_ASSERT_NOW(a_ovf_sat, out_valid && (status == rtfp_pkg::ST_OVERFLOW),
    &integer_value, "overflow without saturation")

endmodule

bind radix_text_to_fixed_point rtfp_checker #(
  .INT_BITS  (INT_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_rtfp_checker (.*);
